// File: rtl/phrt_pkg.sv
// Shared constants, status codes and controller/datapath interface types for the rule hash table.
package phrt_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int SYM_W     = 16;
  localparam int KEY_W     = 2 * SYM_W;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 3;
  localparam int DIV_CNT_W = $clog2(KEY_W);
  localparam int CFG_W     = 16;

  localparam int IN_DATA_W  = 3 * SYM_W + VALUE_W;
  localparam int OUT_BITS   = SLOT_W + VALUE_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [SYM_W-1:0] SYM_ABSENT = 16'hFFFF;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_NT_COUNT   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd4;

  typedef struct packed {
    logic                accept;
    logic                div_step;
    logic                clear_step;
    logic                write_slot;
    logic                advance;
    logic                set_result;
    logic [STATUS_W-1:0] res_status;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic is_lookup;
    logic div_last;
    logic clear_last;
    logic key_empty;
    logic key_match;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/phrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module phrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/phrt_ctrl.sv
// Controller state machine: clearing pass, home-slot division, probe walk and result handoff.
module phrt_ctrl
  import phrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.skip) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ST_SKIPPED;
          state_next     = S_RESULT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.key_match || sts.key_empty) begin
          cmd.set_result = 1'b1;
          if (!sts.is_lookup) begin
            cmd.write_slot = 1'b1;
            cmd.res_status = ST_STORED;
          end else if (sts.key_match) begin
            cmd.res_status = ST_FOUND;
          end else begin
            cmd.res_status = ST_NOT_FOUND;
          end
          state_next = S_RESULT;
        end else if (sts.walk_end) begin
          cmd.set_result = 1'b1;
          cmd.res_status = sts.is_lookup ? ST_NOT_FOUND : ST_FULL;
          state_next     = S_RESULT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/phrt_dpath.sv
// Datapath: configuration registers, key and value stores, restoring divider and probe registers.
module phrt_dpath
  import phrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STATUS_W-1:0]   m_tuser,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [CNT_W-1:0] slot_count;
  logic [SYM_W-1:0] nt_count;
  logic [CNT_W-1:0] n_active;

  logic               op;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic               skip;

  logic [KEY_W-1:0]     div_sh;
  logic [SLOT_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     div_trial;
  logic [SLOT_W-1:0]    rem_next;

  logic [SLOT_W-1:0] pos;
  logic [CNT_W-1:0]  probes;
  logic [CNT_W-1:0]  probes_inc;
  logic [CNT_W-1:0]  pos_inc;
  logic [SLOT_W-1:0] clr_addr;

  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] val_rdata;
  logic               key_we;
  logic [SLOT_W-1:0]  key_waddr;
  logic [KEY_W-1:0]   key_wdata;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [VALUE_W-1:0]  res_value;
  logic [CNT_W-1:0]    res_probes;

  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [VALUE_W-1:0]  out_value;
  logic [CNT_W-1:0]    out_probes;
  logic                out_valid;

  logic [SYM_W-1:0] in_left;
  logic [SYM_W-1:0] in_r1;
  logic [SYM_W-1:0] in_r2;
  logic [KEY_W-1:0] in_key;

  assign in_left = s_tdata[SYM_W-1:0];
  assign in_r1   = s_tdata[2*SYM_W-1:SYM_W];
  assign in_r2   = s_tdata[3*SYM_W-1:2*SYM_W];
  assign in_key  = {in_left, in_r1};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CNT_W'(MAX_SLOTS);
      nt_count   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOT_COUNT: slot_count <= cfg_data[CNT_W-1:0];
        REG_NT_COUNT:   nt_count   <= cfg_data[SYM_W-1:0];
        default:        nt_count   <= nt_count;
      endcase
    end
  end

  always_comb begin
    if (slot_count == '0) begin
      n_active = CNT_W'(1);
    end else if (slot_count > CNT_W'(MAX_SLOTS)) begin
      n_active = CNT_W'(MAX_SLOTS);
    end else begin
      n_active = slot_count;
    end
  end

  assign div_trial  = {rem, div_sh[KEY_W-1]};
  assign rem_next   = (div_trial >= n_active) ? SLOT_W'(div_trial - n_active)
                                              : div_trial[SLOT_W-1:0];
  assign probes_inc = probes + CNT_W'(1);
  assign pos_inc    = {1'b0, pos} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= s_tuser;
      key    <= in_key;
      value  <= s_tdata[IN_DATA_W-1:3*SYM_W];
      skip   <= (s_tuser == OP_INSERT) &&
                ((in_r1 < nt_count) || (in_r2 != SYM_ABSENT) || (in_key == '0));
      div_sh <= in_key;
      rem    <= '0;
    end
    if (cmd.div_step) begin
      div_sh <= {div_sh[KEY_W-2:0], 1'b0};
      rem    <= rem_next;
      if (sts.div_last) begin
        pos    <= rem_next;
        probes <= '0;
      end
    end
    if (cmd.advance) begin
      probes <= probes_inc;
      pos    <= (pos_inc >= n_active) ? '0 : pos_inc[SLOT_W-1:0];
    end
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      res_probes <= (cmd.res_status == ST_SKIPPED) ? '0 : probes_inc;
      res_slot   <= ((cmd.res_status == ST_STORED) || (cmd.res_status == ST_FOUND))
                    ? pos : '0;
      res_value  <= (cmd.res_status == ST_FOUND) ? val_rdata : '0;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_value  <= res_value;
      out_probes <= res_probes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign key_we    = cmd.clear_step | cmd.write_slot;
  assign key_waddr = cmd.clear_step ? clr_addr : pos;
  assign key_wdata = cmd.clear_step ? '0 : key;

  phrt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_wdata),
    .raddr(pos),
    .rdata(key_rdata)
  );

  phrt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_SLOTS)
  ) u_val_ram (
    .clk  (clk),
    .we   (cmd.write_slot),
    .waddr(pos),
    .wdata(value),
    .raddr(pos),
    .rdata(val_rdata)
  );

  assign sts.skip       = skip;
  assign sts.is_lookup  = (op == OP_LOOKUP);
  assign sts.div_last   = (div_cnt == DIV_CNT_W'(KEY_W - 1));
  assign sts.clear_last = (clr_addr == SLOT_W'(MAX_SLOTS - 1));
  assign sts.key_empty  = (key_rdata == '0);
  assign sts.key_match  = (key_rdata == key);
  assign sts.walk_end   = (probes_inc >= n_active);
  assign sts.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_DATA_W - SLOT_W - VALUE_W - CNT_W){1'b0}},
                     out_probes, out_value, out_slot};

endmodule

// File: rtl/preterminal_rule_hash_table_core.sv
// Top level of the preterminal rule hash table: controller and datapath.
//
//   Channel   Signals                               Payload
//   cfg       cfg_valid, cfg_ready                  cfg_index, cfg_data
//   s (in)    s_tvalid, s_tready                    s_tuser op, s_tdata rule
//   m (out)   m_tvalid, m_tready                    m_tuser status, m_tdata result
//
// An item is accepted in the idle state. Its result is handed to the output register after
// a start state, the bit-serial remainder that gives the home slot, a store read and then a
// compare for each probed slot, and a handoff state; a skipped insert goes from the start
// state straight to the handoff, after which the controller returns to idle. After reset a
// clearing pass writes all 1024 key slots, one per cycle, before the first item is accepted.
// The output register lets a new item be accepted while the previous result waits for
// m_tready; the handoff stalls while that register is full and m_tready is low.
module preterminal_rule_hash_table_core
  import phrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,   // op
  input  logic [IN_DATA_W-1:0]  s_tdata,   // left_symbol, right_first, right_second, rule_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STATUS_W-1:0]   m_tuser,   // status
  output logic [OUT_DATA_W-1:0] m_tdata    // slot_index, found_value, probes_used, zero fill
);

  cmd_t cmd;
  sts_t sts;

  phrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  phrt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: tb/tb_preterminal_rule_hash_table_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the preterminal rule hash table core with a linear probing predictor.
module tb_preterminal_rule_hash_table_core
  import phrt_pkg::*;
();

  localparam int VAL_LO  = SLOT_W;
  localparam int PRB_LO  = SLOT_W + VALUE_W;
  localparam int FILL_LO = PRB_LO + CNT_W;

  typedef struct packed {
    logic               op;
    logic [SYM_W-1:0]   left_sym;
    logic [SYM_W-1:0]   right_first;
    logic [SYM_W-1:0]   right_second;
    logic [VALUE_W-1:0] payload;
  } rule_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  value;
    logic [CNT_W-1:0]    probes;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = REG_SLOT_COUNT;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic                  s_tuser = OP_INSERT;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [STATUS_W-1:0]   m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [KEY_W-1:0]   slot_key_mirror [MAX_SLOTS];
  logic [VALUE_W-1:0] slot_value_mirror [MAX_SLOTS];
  logic [CNT_W-1:0]   slot_count_reg = CNT_W'(MAX_SLOTS);
  logic [SYM_W-1:0]   nt_count_reg = '0;

  rule_t            pending_rules [$];
  answer_t          expected_answers [$];
  logic [KEY_W-1:0] known_keys [$];
  rule_t            cur_rule;
  answer_t          want;
  bit               calm = 1'b0;
  int               errors = 0;

  preterminal_rule_hash_table_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walks the mirrored table the way the block does and updates it on a store.
  function automatic answer_t probe_table(rule_t r);
    logic [KEY_W-1:0] key;
    int unsigned      n;
    int unsigned      pos;
    int unsigned      probes;
    answer_t          a;
    bit               done;
    key = {r.left_sym, r.right_first};
    n = 32'(slot_count_reg);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_SLOTS) begin
      n = MAX_SLOTS;
    end
    pos = key % n;
    probes = 0;
    a = '0;
    done = 1'b0;
    if (r.op == OP_INSERT && (r.right_first < nt_count_reg || r.right_second != SYM_ABSENT ||
        key == '0)) begin
      a.status = ST_SKIPPED;
      done = 1'b1;
    end else begin
      a.status = (r.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end
    while (!done && probes < n) begin
      probes++;
      if (slot_key_mirror[SLOT_W'(pos)] == '0 || slot_key_mirror[SLOT_W'(pos)] == key) begin
        if (r.op == OP_INSERT) begin
          slot_key_mirror[SLOT_W'(pos)] = key;
          slot_value_mirror[SLOT_W'(pos)] = r.payload;
          a.status = ST_STORED;
          a.slot = SLOT_W'(pos);
        end else if (slot_key_mirror[SLOT_W'(pos)] == key) begin
          a.status = ST_FOUND;
          a.slot = SLOT_W'(pos);
          a.value = slot_value_mirror[SLOT_W'(pos)];
        end else begin
          a.status = ST_NOT_FOUND;
        end
        done = 1'b1;
      end else begin
        pos++;
        if (pos >= n) begin
          pos = 0;
        end
      end
    end
    a.probes = CNT_W'(probes);
    return a;
  endfunction

  function automatic rule_t make_rule();
    rule_t       r;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    r.op = OP_INSERT;
    r.left_sym = SYM_W'($urandom);
    r.right_first = SYM_W'($urandom);
    r.right_second = SYM_W'($urandom);
    r.payload = {$urandom, $urandom};
    if (pick < 45) begin
      r.right_second = SYM_ABSENT;
      if (known_keys.size() > 0 && $urandom_range(2, 0) == 0) begin
        {r.left_sym, r.right_first} = known_keys[$urandom_range(known_keys.size() - 1, 0)];
      end else begin
        r.right_first = SYM_W'($urandom_range(16'hFFFF, nt_count_reg));
        known_keys.insert(known_keys.size(), {r.left_sym, r.right_first});
      end
    end else if (pick < 82) begin
      r.op = OP_LOOKUP;
      if (known_keys.size() > 0 && $urandom_range(3, 0) != 0) begin
        {r.left_sym, r.right_first} = known_keys[$urandom_range(known_keys.size() - 1, 0)];
      end
      if ({r.left_sym, r.right_first} == '0) begin
        r.right_first = 16'd1;
      end
    end else if (pick < 90 && nt_count_reg != '0) begin
      r.right_second = SYM_ABSENT;
      r.right_first = SYM_W'($urandom_range(nt_count_reg - 1, 0));
    end else if (pick < 93) begin
      r.left_sym = '0;
      r.right_first = '0;
      r.right_second = SYM_ABSENT;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] exp_val);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  task automatic add_rule(input logic op, input logic [SYM_W-1:0] left_sym,
                          input logic [SYM_W-1:0] right_first,
                          input logic [SYM_W-1:0] right_second,
                          input logic [VALUE_W-1:0] payload);
    rule_t r;
    r = '{op, left_sym, right_first, right_second, payload};
    pending_rules.insert(pending_rules.size(), r);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SLOT_COUNT) begin
      slot_count_reg = data[CNT_W-1:0];
    end else begin
      nt_count_reg = data;
    end
  endtask

  task automatic drain();
    while (pending_rules.size() > 0 || s_tvalid || expected_answers.size() > 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] slots, input logic [CFG_W-1:0] nts,
                              input int count, input bit quiet);
    write_reg(REG_SLOT_COUNT, slots);
    write_reg(REG_NT_COUNT, nts);
    calm = quiet;
    repeat (count) pending_rules.insert(pending_rules.size(), make_rule());
    drain();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_answers.insert(expected_answers.size(), probe_table(cur_rule));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_rules.size() > 0 && (calm || $urandom_range(99, 0) >= 23)) begin
          cur_rule = pending_rules.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_rule.op;
          s_tdata <= {cur_rule.payload, cur_rule.right_second, cur_rule.right_first,
                      cur_rule.left_sym};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected item", VALUE_W'(m_tuser), '0);
        end else begin
          want = expected_answers.pop_front();
          if (m_tuser !== want.status) begin
            report_mismatch("status", VALUE_W'(m_tuser), VALUE_W'(want.status));
          end
          if (m_tdata[SLOT_W-1:0] !== want.slot) begin
            report_mismatch("slot_index", VALUE_W'(m_tdata[SLOT_W-1:0]), VALUE_W'(want.slot));
          end
          if (m_tdata[PRB_LO-1:VAL_LO] !== want.value) begin
            report_mismatch("found_value", m_tdata[PRB_LO-1:VAL_LO], want.value);
          end
          if (m_tdata[FILL_LO-1:PRB_LO] !== want.probes) begin
            report_mismatch("probes_used", VALUE_W'(m_tdata[FILL_LO-1:PRB_LO]),
                            VALUE_W'(want.probes));
          end
          if (m_tdata[OUT_DATA_W-1:FILL_LO] !== '0) begin
            report_mismatch("zero fill", VALUE_W'(m_tdata[OUT_DATA_W-1:FILL_LO]), '0);
          end
        end
      end
      m_tready <= calm || $urandom_range(99, 0) >= 23;
    end
  end

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_key_mirror[SLOT_W'(i)] = '0;
      slot_value_mirror[SLOT_W'(i)] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_rule(OP_INSERT, 16'h0000, 16'h0000, SYM_ABSENT, 64'h1111_2222_3333_4444);
    add_rule(OP_INSERT, 16'hFFFF, 16'hFFFF, SYM_ABSENT, '1);
    add_rule(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h1234, 64'h0123_4567_89AB_CDEF);
    add_rule(OP_INSERT, 16'h0000, 16'h07FF, SYM_ABSENT, 64'hA5A5_5A5A_F0F0_0F0F);
    add_rule(OP_INSERT, 16'h0005, 16'h0005, 16'h0000, 64'h5);
    add_rule(OP_INSERT, 16'h0000, 16'h0001, SYM_ABSENT, '0);
    add_rule(OP_INSERT, 16'h0000, 16'h0001, SYM_ABSENT, 64'hDEAD_BEEF_CAFE_F00D);
    add_rule(OP_LOOKUP, 16'h0000, 16'h0001, SYM_ABSENT, '0);
    add_rule(OP_INSERT, 16'h0000, 16'h0401, SYM_ABSENT, 64'h8000_0000_0000_0001);
    add_rule(OP_LOOKUP, 16'h0000, 16'h0801, SYM_ABSENT, '0);
    add_rule(OP_LOOKUP, 16'h0000, 16'h0401, 16'hFFFE, '1);
    add_rule(OP_LOOKUP, 16'hFFFF, 16'h03FF, SYM_ABSENT, '0);
    drain();

    write_reg(REG_NT_COUNT, 16'h8000);
    write_reg(REG_SLOT_COUNT, 16'd4);
    add_rule(OP_INSERT, 16'h0003, 16'h7FFF, SYM_ABSENT, 64'h77);
    add_rule(OP_INSERT, 16'h0003, 16'h8000, SYM_ABSENT, 64'h88);
    add_rule(OP_INSERT, 16'h0004, 16'h8001, SYM_ABSENT, 64'h99);
    add_rule(OP_LOOKUP, 16'h0004, 16'h8001, SYM_ABSENT, '0);
    add_rule(OP_LOOKUP, 16'h0000, 16'h0401, SYM_ABSENT, '0);
    drain();

    write_reg(REG_SLOT_COUNT, 16'd0);
    add_rule(OP_LOOKUP, 16'h0000, 16'h0000, SYM_ABSENT, '0);
    add_rule(OP_LOOKUP, 16'h0000, 16'h07FF, SYM_ABSENT, '0);
    add_rule(OP_INSERT, 16'h0009, 16'hFFFF, SYM_ABSENT, 64'hAA);
    drain();

    write_reg(REG_SLOT_COUNT, 16'd2047);
    write_reg(REG_NT_COUNT, 16'hFFFF);
    add_rule(OP_INSERT, 16'h1234, 16'hFFFE, SYM_ABSENT, 64'hBB);
    add_rule(OP_INSERT, 16'h1234, 16'hFFFF, SYM_ABSENT, 64'hFEDC_BA98_7654_3210);
    add_rule(OP_LOOKUP, 16'h1234, 16'hFFFF, 16'h0000, '0);
    drain();

    random_phase(16'd1024, 16'h0100, 150, 1'b0);
    random_phase(16'd13, 16'h0000, 60, 1'b0);
    random_phase(16'd1, 16'h8000, 20, 1'b0);
    random_phase(16'd2047, 16'hFFFF, 40, 1'b0);
    random_phase(16'd1024, 16'h0000, 150, 1'b1);
    random_phase(16'd600, 16'h1000, 130, 1'b0);

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("preterminal_rule_hash_table_core verification clean");
    end else begin
      $display("preterminal_rule_hash_table_core verification failed");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("preterminal_rule_hash_table_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/phrt_pkg.sv
rtl/phrt_ram.sv
rtl/phrt_ctrl.sv
rtl/phrt_dpath.sv
rtl/preterminal_rule_hash_table_core.sv
tb/tb_preterminal_rule_hash_table_core.sv
